[rtl/core/rgbxf_pkg.sv]
// Package for the packed RGB crossfade overlay.
// Fade envelope breakpoints, factor struct and ramp threshold function.
// No dependencies.
package rgbxf_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned PackedW  = 30;
  localparam int unsigned RgbW     = 24;
  localparam int unsigned FactorW  = 6;
  localparam int unsigned DtW      = 12;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned FactorMax = 32;
  localparam int unsigned InDataW  = 88;

  localparam logic [TimeW-1:0] T_FADE_IN_END  = 16'd1500;
  localparam logic [TimeW-1:0] T_HOLD_END     = 16'd4000;
  localparam logic [TimeW-1:0] T_CROSS_END    = 16'd6000;
  localparam logic [TimeW-1:0] T_FADE_OUT_END = 16'd9000;

  localparam int unsigned SPAN_FADE_IN  = 1500;
  localparam int unsigned SPAN_HOLD     = 2500;
  localparam int unsigned SPAN_CROSS    = 2000;
  localparam int unsigned SPAN_FADE_OUT = 3000;

  // factor = floor(dt * 329 / (10 * span))
  localparam int unsigned RAMP_NUM = 329;

  typedef enum logic [0:0] {
    CFG_ENABLE  = 1'b0,
    CFG_ELAPSED = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEG_FADE_IN,
    SEG_HOLD,
    SEG_CROSS,
    SEG_FADE_OUT
  } seg_e;

  typedef struct packed {
    logic               bypass;
    logic [FactorW-1:0] first;
    logic [FactorW-1:0] second;
  } fade_t;

  // smallest dt at which the factor reaches k
  function automatic logic [DtW-1:0] ramp_threshold(input int unsigned k,
                                                    input int unsigned span);
    int unsigned prod;
    prod = k * span * 10 + RAMP_NUM - 1;
    return DtW'(prod / RAMP_NUM);
  endfunction

endpackage

[rtl/core/rgbxf_envelope.sv]
// Fade envelope: elapsed time to the two overlay factors, registered.
// Depends on rgbxf_pkg.
module rgbxf_envelope (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          enable_i,
  input  logic [rgbxf_pkg::TimeW-1:0]   elapsed_i,
  output rgbxf_pkg::fade_t              fade_o
);

  rgbxf_pkg::fade_t                   fade_d, fade_q;
  rgbxf_pkg::seg_e                    seg;
  logic [rgbxf_pkg::TimeW-1:0]        diff;
  logic [rgbxf_pkg::DtW-1:0]          dt;
  logic [rgbxf_pkg::DtW-1:0]          thr;
  logic [rgbxf_pkg::FactorMax-1:0]    reached;
  logic [rgbxf_pkg::FactorW-1:0]      ramp;

  always_comb begin
    if (elapsed_i < rgbxf_pkg::T_FADE_IN_END) begin
      seg  = rgbxf_pkg::SEG_FADE_IN;
      diff = elapsed_i;
    end else if (elapsed_i < rgbxf_pkg::T_HOLD_END) begin
      seg  = rgbxf_pkg::SEG_HOLD;
      diff = elapsed_i - rgbxf_pkg::T_FADE_IN_END;
    end else if (elapsed_i < rgbxf_pkg::T_CROSS_END) begin
      seg  = rgbxf_pkg::SEG_CROSS;
      diff = rgbxf_pkg::T_CROSS_END - elapsed_i;
    end else begin
      seg  = rgbxf_pkg::SEG_FADE_OUT;
      diff = rgbxf_pkg::T_FADE_OUT_END - elapsed_i;
    end
    dt = diff[rgbxf_pkg::DtW-1:0];

    // thresholds rise with k, so the count of those passed is the factor
    for (int k = 0; k < rgbxf_pkg::FactorMax; k++) begin
      case (seg)
        rgbxf_pkg::SEG_FADE_IN:
          thr = rgbxf_pkg::ramp_threshold(k + 1, rgbxf_pkg::SPAN_FADE_IN);
        rgbxf_pkg::SEG_HOLD:
          thr = rgbxf_pkg::ramp_threshold(k + 1, rgbxf_pkg::SPAN_HOLD);
        rgbxf_pkg::SEG_CROSS:
          thr = rgbxf_pkg::ramp_threshold(k + 1, rgbxf_pkg::SPAN_CROSS);
        default:
          thr = rgbxf_pkg::ramp_threshold(k + 1, rgbxf_pkg::SPAN_FADE_OUT);
      endcase
      reached[k] = (dt >= thr);
    end
    ramp = rgbxf_pkg::FactorW'($countones(reached));

    fade_d.bypass = !enable_i || (elapsed_i >= rgbxf_pkg::T_FADE_OUT_END);
    case (seg)
      rgbxf_pkg::SEG_FADE_IN: begin
        fade_d.first  = ramp;
        fade_d.second = '0;
      end
      rgbxf_pkg::SEG_HOLD: begin
        fade_d.first  = rgbxf_pkg::FactorW'(rgbxf_pkg::FactorMax);
        fade_d.second = ramp;
      end
      rgbxf_pkg::SEG_CROSS: begin
        fade_d.first  = ramp;
        fade_d.second = rgbxf_pkg::FactorW'(rgbxf_pkg::FactorMax);
      end
      default: begin
        fade_d.first  = '0;
        fade_d.second = ramp;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q <= '{bypass: 1'b1, first: '0, second: '0};
    end else begin
      fade_q <= fade_d;
    end
  end

  assign fade_o = fade_q;

endmodule

[rtl/core/rgbxf_blend.sv]
// Per-channel scale, saturating overlay sum and saturating add to background.
// Depends on rgbxf_pkg.
module rgbxf_blend (
  input  logic [rgbxf_pkg::PackedW-1:0] first_i,
  input  logic [rgbxf_pkg::PackedW-1:0] second_i,
  input  logic [rgbxf_pkg::RgbW-1:0]    background_i,
  input  rgbxf_pkg::fade_t              fade_i,
  output logic [rgbxf_pkg::RgbW-1:0]    blended_o
);

  localparam int unsigned PackFieldW = 10;
  localparam int unsigned KeepW      = 5;
  localparam int unsigned KeepLsb    = 3;
  localparam int unsigned ProdW      = KeepW + rgbxf_pkg::FactorW;

  logic [KeepW-1:0]              c_first, c_second;
  logic [ProdW-1:0]              p_first, p_second;
  logic [rgbxf_pkg::ChanW-1:0]   s_first, s_second, ov, bg;
  logic [rgbxf_pkg::ChanW:0]     ov_sum, dst_sum;
  logic [rgbxf_pkg::RgbW-1:0]    mixed;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      c_first  = first_i[ch*PackFieldW + KeepLsb +: KeepW];
      c_second = second_i[ch*PackFieldW + KeepLsb +: KeepW];
      p_first  = ProdW'(c_first) * ProdW'(fade_i.first);
      p_second = ProdW'(c_second) * ProdW'(fade_i.second);
      // product >> 2, keep top five bits of the channel
      s_first  = {p_first[ProdW-2 -: KeepW], 3'b000};
      s_second = {p_second[ProdW-2 -: KeepW], 3'b000};
      ov_sum   = {1'b0, s_first} + {1'b0, s_second};
      ov       = ov_sum[rgbxf_pkg::ChanW] ? '1 : ov_sum[rgbxf_pkg::ChanW-1:0];
      bg       = background_i[ch*rgbxf_pkg::ChanW +: rgbxf_pkg::ChanW];
      dst_sum  = {1'b0, bg} + {1'b0, ov};
      mixed[ch*rgbxf_pkg::ChanW +: rgbxf_pkg::ChanW] =
        dst_sum[rgbxf_pkg::ChanW] ? '1 : dst_sum[rgbxf_pkg::ChanW-1:0];
    end
    blended_o = fade_i.bypass ? background_i : mixed;
  end

endmodule

[rtl/core/packed_rgb_crossfade_overlay.sv]
// Top level of the packed RGB crossfade overlay: config registers, pixel pipeline.
// Depends on rgbxf_pkg, rgbxf_envelope and rgbxf_blend.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid_i/tready_o     first, second, background pixel
//  m_axis    out        m_axis_tvalid_o/tready_i     blended pixel
//  cfg       in         cfg_valid_i/cfg_ready_o      register index, write data
//
// One pixel per clock while the result side accepts and cfg_valid_i is low; a
// request passes the input register, then the result register. Factors are
// registered from the config registers every cycle, so the pixel datapath is one
// mask, small multiply and two saturating adds. Reset leaves the overlay disabled.
// A stalled result holds the result register; a free input register takes a request.
module packed_rgb_crossfade_overlay (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // [29:0] first_pixel, [59:30] second_pixel, [83:60] background_pixel, [87:84] zero
  input  logic [rgbxf_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [23:0] blended_pixel
  output logic [rgbxf_pkg::RgbW-1:0]      m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [rgbxf_pkg::TimeW-1:0]     cfg_data_i
);

  localparam int unsigned SecondLsb = rgbxf_pkg::PackedW;
  localparam int unsigned BgLsb     = 2 * rgbxf_pkg::PackedW;

  logic                            enable_q, enable_d;
  logic [rgbxf_pkg::TimeW-1:0]     elapsed_q, elapsed_d;
  logic                            s1_valid_q, s1_valid_d;
  logic [rgbxf_pkg::PackedW-1:0]   s1_first_q, s1_second_q;
  logic [rgbxf_pkg::RgbW-1:0]      s1_bg_q;
  logic                            out_valid_q, out_valid_d;
  logic [rgbxf_pkg::RgbW-1:0]      out_data_q;
  logic [rgbxf_pkg::RgbW-1:0]      blended;
  rgbxf_pkg::fade_t                fade;
  logic                            advance, load_s1, cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    enable_d  = enable_q;
    elapsed_d = elapsed_q;
    if (cfg_write) begin
      case (cfg_index_i)
        rgbxf_pkg::CFG_ENABLE:  enable_d  = cfg_data_i[0];
        rgbxf_pkg::CFG_ELAPSED: elapsed_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (!s1_valid_q || advance) && !cfg_valid_i;
  assign load_s1         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (load_s1) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      elapsed_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      enable_q    <= enable_d;
      elapsed_q   <= elapsed_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s1) begin
      s1_first_q  <= s_axis_tdata_i[rgbxf_pkg::PackedW-1:0];
      s1_second_q <= s_axis_tdata_i[SecondLsb +: rgbxf_pkg::PackedW];
      s1_bg_q     <= s_axis_tdata_i[BgLsb +: rgbxf_pkg::RgbW];
    end
    if (advance && s1_valid_q) begin
      out_data_q <= blended;
    end
  end

  rgbxf_envelope u_envelope (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .enable_i  (enable_q),
    .elapsed_i (elapsed_q),
    .fade_o    (fade)
  );

  rgbxf_blend u_blend (
    .first_i      (s1_first_q),
    .second_i     (s1_second_q),
    .background_i (s1_bg_q),
    .fade_i       (fade),
    .blended_o    (blended)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[tb/sv/tb_packed_rgb_crossfade_overlay.sv]
`timescale 1ns / 1ps
// Self-checking testbench for packed_rgb_crossfade_overlay: directed and random pixel
// requests across many fade settings, checked against an in-bench blend predictor.
// Depends on rgbxf_pkg and the packed_rgb_crossfade_overlay RTL.
module tb_packed_rgb_crossfade_overlay;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned ReportLimit = 10;
  localparam logic [31:0] ChanMask    = 32'h0F83E0F8;
  localparam logic [31:0] CarryMask   = 32'h10040100;

  typedef struct packed {
    logic [23:0] background;
    logic [29:0] second;
    logic [29:0] first;
  } pixel_req_t;

  class pixel_blend_checker;
    logic        enable;
    logic [15:0] elapsed;
    logic [23:0] expected_pixels_q[$];
    int unsigned failures;

    function new();
      enable   = 1'b0;
      elapsed  = '0;
      failures = 0;
    endfunction

    function void write_reg(rgbxf_pkg::cfg_idx_e idx, logic [15:0] val);
      if (idx == rgbxf_pkg::CFG_ENABLE) begin
        enable = val[0];
      end else begin
        elapsed = val;
      end
    endfunction

    function logic [5:0] fade_step(int unsigned dt, int unsigned span);
      return 6'((dt * 329) / (span * 10));
    endfunction

    function logic [31:0] saturate_channels(logic [31:0] v);
      logic [31:0] c;
      c = v & CarryMask;
      return (v - c) | (c - (c >> 8));
    endfunction

    function logic [31:0] scaled_overlay(logic [29:0] p, logic [5:0] f);
      logic [31:0] v;
      v = {2'b00, p} & ChanMask;
      v = ((v >> 3) * f) >> 2;
      return v & ChanMask;
    endfunction

    function logic [23:0] blended_pixel_for(pixel_req_t r);
      logic [5:0]  f1;
      logic [5:0]  f2;
      logic [31:0] sum;
      logic [31:0] bg_p;
      logic [31:0] dst;
      int unsigned t;
      t  = elapsed;
      f1 = '0;
      f2 = '0;
      if (!enable || t >= 9000) return r.background;
      if (t < 1500) begin
        f1 = fade_step(t, 1500);
      end else if (t < 4000) begin
        f1 = 6'd32;
        f2 = fade_step(t - 1500, 2500);
      end else if (t < 6000) begin
        f1 = fade_step(6000 - t, 2000);
        f2 = 6'd32;
      end else begin
        f2 = fade_step(9000 - t, 3000);
      end
      sum  = saturate_channels(scaled_overlay(r.first, f1) + scaled_overlay(r.second, f2));
      bg_p = {4'b0, r.background[23:16], 2'b0, r.background[15:8], 2'b0, r.background[7:0]};
      dst  = saturate_channels(bg_p + sum);
      return {dst[27:20], dst[17:10], dst[7:0]};
    endfunction

    function void note_pixel_request(pixel_req_t r);
      expected_pixels_q = {expected_pixels_q, blended_pixel_for(r)};
    endfunction

    function void check_blended_pixel(logic [23:0] got);
      logic [23:0] want;
      if (expected_pixels_q.size() == 0) begin
        failures++;
        if (failures <= ReportLimit) $display("unexpected result %06h", got);
        return;
      end
      want = expected_pixels_q.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("blended_pixel mismatch: expected %06h, got %06h", want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_pixels_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [rgbxf_pkg::InDataW-1:0] s_axis_tdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [rgbxf_pkg::RgbW-1:0] m_axis_tdata_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [rgbxf_pkg::TimeW-1:0] cfg_data_i = '0;

  pixel_blend_checker blend_chk = new();
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned cycles = 0;

  packed_rgb_crossfade_overlay i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .m_axis_tdata_o,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [29:0] draw_overlay();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return 30'($urandom) | 30'h0F83E0F8;
      default: return 30'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] draw_background();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return 24'($urandom) | 24'hE0E0E0;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic pixel_req_t directed_req(int unsigned k);
    pixel_req_t r;
    case (k)
      0: r = '{background: 24'h000000, second: 30'h0, first: 30'h0};
      1: r = '{background: 24'hFFFFFF, second: 30'h3FFFFFFF, first: 30'h3FFFFFFF};
      2: r = '{background: 24'h000000, second: 30'h0FF3FCFF, first: 30'h0FF3FCFF};
      3: r = '{background: 24'h808080, second: 30'h300C0300, first: 30'h300C0300};
      default: r = '{background: 24'h7F7F7F, second: 30'h00701C07, first: 30'h0F83E0F8};
    endcase
    return r;
  endfunction

  task automatic write_reg(input rgbxf_pkg::cfg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    blend_chk.write_reg(idx, val);
  endtask

  task automatic send_pixel(input pixel_req_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, r.background, r.second, r.first};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    blend_chk.note_pixel_request(r);
  endtask

  // settings change only once the pipeline has drained
  task automatic run_phase(input logic en, input logic [15:0] t, input int unsigned n,
                           input bit directed, input bit hold);
    pixel_req_t r;
    while (blend_chk.pending() != 0) @(posedge clk_i);
    write_reg(rgbxf_pkg::CFG_ENABLE, {15'b0, en});
    write_reg(rgbxf_pkg::CFG_ELAPSED, t);
    cfg_valid_i <= 1'b0;
    idle_on  = ($urandom_range(0, 3) != 0);
    hold_req = hold;
    for (int unsigned i = 0; i < n; i++) begin
      if (directed) begin
        r = directed_req(i);
      end else begin
        r.background = draw_background();
        r.second     = draw_overlay();
        r.first      = draw_overlay();
      end
      send_pixel(r);
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned gap;
    forever begin
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      blend_chk.check_blended_pixel(m_axis_tdata_o);
    end
  end

  initial begin
    logic [15:0] edge_times [12];
    logic [15:0] t;
    edge_times = '{16'd0, 16'd1, 16'd1499, 16'd1500, 16'd2750, 16'd3999, 16'd4000,
                   16'd5999, 16'd6000, 16'd8999, 16'd9000, 16'd65535};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled, both factors zero, hold, full crossfade, past the envelope
    run_phase(1'b0, 16'd3000,  5, 1'b1, 1'b0);
    run_phase(1'b1, 16'd0,     5, 1'b1, 1'b0);
    run_phase(1'b1, 16'd2750,  5, 1'b1, 1'b0);
    run_phase(1'b1, 16'd4000,  5, 1'b1, 1'b0);
    run_phase(1'b1, 16'd9000,  5, 1'b1, 1'b0);

    for (int unsigned p = 0; p < 16; p++) begin
      if (p < 12) begin
        t = edge_times[p];
      end else if ($urandom_range(0, 3) == 0) begin
        t = 16'($urandom_range(9000, 65535));
      end else begin
        t = 16'($urandom_range(0, 8999));
      end
      run_phase((p < 12) ? 1'b1 : ($urandom_range(0, 4) != 0), t, 58, 1'b0, p == 4);
    end

    while (blend_chk.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (blend_chk.failures == 0 && blend_chk.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
